@@ hdl/gwm_pkg.sv @@
`default_nettype none

package gwm_pkg;

    // Fixed by the register layout: sixteen pattern characters in two 64-bit words.
    localparam int MAX_PATTERN_DEF = 16;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CHARS_W         = 2 * CFG_DATA_W;

    localparam logic [BYTE_W-1:0] STAR_CHAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_CHAR   = 8'h3F;
    localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH     = 2'd2;

    // Per-position setup derived from the pattern registers.
    typedef struct packed {
        logic [BYTE_W-1:0] pchar;
        logic              active;   // position lies before the pattern end
        logic              live;     // position lies at or before the pattern end
    } gwm_cell_cfg_t;

    // Signals handed from one position to the next.
    typedef struct packed {
        logic close1;   // star closure over the stored vector
        logic step;     // character consumed by the previous position
        logic close2;   // star closure over the advanced vector
    } gwm_link_t;

    typedef struct packed {
        logic closed1;
        logic closed2;
    } gwm_tap_t;

endpackage

`default_nettype wire

@@ hdl/gwm_cell.sv @@
`default_nettype none

module gwm_cell
    import gwm_pkg::*;
#(
    parameter bit IS_ORIGIN = 1'b0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take,
    input  wire logic              last,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire gwm_cell_cfg_t     cfg,
    input  wire gwm_link_t         link_in,
    output gwm_link_t              link_out,
    output gwm_tap_t               tap
);

    logic reached_reg;
    logic reached_next;
    logic is_star;
    logic char_hit;
    logic closed1;
    logic step_bit;
    logic closed2;

    always_comb begin
        is_star  = (cfg.pchar == STAR_CHAR);
        char_hit = (cfg.pchar == ANY_CHAR) || (cfg.pchar == text_byte);

        closed1 = cfg.live & (reached_reg | link_in.close1);

        // A star position stays reached while it swallows the byte.
        step_bit = cfg.live & (link_in.step | (closed1 & cfg.active & is_star));
        closed2  = cfg.live & (step_bit | link_in.close2);

        link_out.close1 = closed1 & cfg.active & is_star;
        link_out.step   = closed1 & cfg.active & ~is_star & char_hit;
        link_out.close2 = closed2 & cfg.active & is_star;

        tap.closed1 = closed1;
        tap.closed2 = closed2;

        reached_next = last ? IS_ORIGIN : closed2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reached_reg <= IS_ORIGIN;
        end else if (take) begin
            reached_reg <= reached_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/glob_wildcard_matcher_unit.sv @@
`default_nettype none

// Channel   Direction  Payload                              Handshake
// s_        in         tdata[7:0] text_byte, tlast end      s_tvalid / s_tready
// m_        out        tdata[0] matched, [7:1] zero         m_tvalid / m_tready
// cfg_      in         cfg_index register, cfg_data value   cfg_valid / cfg_ready
//
// One item is taken per cycle while s_tready is high; the whole position vector advances on each
// taken item through the row of position cells, whose star-closure ripple sets the critical path.
// A result is registered into the output queue when the item with tlast is taken,
// behind any result still waiting.
// Results wait in a two-entry output queue; s_tready drops only when both entries are full.
// Synchronous active-low reset sets the vector to position zero and clears the pattern registers and the queue count.

module glob_wildcard_matcher_unit
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,     // [7:0] text_byte
    input  wire logic                  s_tlast,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [BYTE_W-1:0]          m_tdata,     // [0] matched, [7:1] zero

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NCELL = MAX_PATTERN + 1;
    localparam int IDX_W = $clog2(NCELL);

    logic [LEN_W-1:0]   len_reg;
    logic [CHARS_W-1:0] chars_reg;
    logic [LEN_W-1:0]   used_len;

    logic               take;
    logic               slash_last;
    logic               result_bit;

    gwm_link_t          links [NCELL+1];
    gwm_tap_t           taps  [NCELL];
    logic [NCELL-1:0]   closed1_vec;
    logic [NCELL-1:0]   closed2_vec;

    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               q0_reg;
    logic               q0_next;
    logic               q1_reg;
    logic               q1_next;
    logic               push;
    logic               pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            chars_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                REG_CHARS_LOW:      chars_reg[CFG_DATA_W-1:0] <= cfg_data;
                REG_CHARS_HIGH:     chars_reg[CHARS_W-1:CFG_DATA_W] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign used_len = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    assign take       = s_tvalid && s_tready;
    assign slash_last = s_tlast && (s_tdata == SLASH_CHAR);

    assign links[0] = '0;

    for (genvar p = 0; p < NCELL; p++) begin : g_cell
        gwm_cell_cfg_t cell_cfg;

        if (p < MAX_PATTERN) begin : g_char
            assign cell_cfg.pchar = chars_reg[p*BYTE_W +: BYTE_W];
        end else begin : g_end
            assign cell_cfg.pchar = '0;
        end
        assign cell_cfg.active = (LEN_W'(p) < used_len);
        assign cell_cfg.live   = (LEN_W'(p) <= used_len);

        gwm_cell #(
            .IS_ORIGIN (p == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .take      (take),
            .last      (s_tlast),
            .text_byte (s_tdata),
            .cfg       (cell_cfg),
            .link_in   (links[p]),
            .link_out  (links[p+1]),
            .tap       (taps[p])
        );

        assign closed1_vec[p] = taps[p].closed1;
        assign closed2_vec[p] = taps[p].closed2;
    end

    // A trailing slash is not consumed, so the stored vector is judged as it stands.
    assign result_bit = slash_last ? closed1_vec[used_len[IDX_W-1:0]]
                                   : closed2_vec[used_len[IDX_W-1:0]];

    assign push = take && s_tlast;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (pop) begin
            q0_next = q1_reg;
        end
        if (push) begin
            if ((count_reg - {1'b0, pop}) == 2'd0) begin
                q0_next = result_bit;
            end else begin
                q1_next = result_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign s_tready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {{(BYTE_W-1){1'b0}}, q0_reg};

endmodule

`default_nettype wire

@@ hdl/gwm_checker.sv @@
`default_nettype none

module gwm_checker
    import gwm_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              s_tlast,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [BYTE_W-1:0] m_tdata
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("gwm: stalled result changed");

    // Reset empties the output queue.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("gwm: result present after reset");

    // A new result follows only an item that closed a string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("gwm: result without a final item");

    // Input stalls only while results are pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && (m_tdata[BYTE_W-1:1] == '0))
        else $error("gwm: input stalled with no pending result");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/glob_wildcard_matcher_unit_tb.sv @@
`timescale 1ns / 1ps

module glob_wildcard_matcher_unit_tb;
    import gwm_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_CHARS = 1750;
    localparam int DIR_N        = 36;

    typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [BYTE_W-1:0]     ch;
        logic                  last;
        logic                  typed;   // verdict below is written out by hand
        logic                  want;
    } dir_row_t;

    typedef struct packed {
        logic typed;
        logic want;
    } char_tag_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;    // [7:0] text_byte
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;           // [0] matched, [7:1] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    glob_wildcard_matcher_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the pattern registers and of the reached-position vector.
    logic [LEN_W-1:0]      pat_len = '0;
    logic [CFG_DATA_W-1:0] pat_lo  = '0;
    logic [CFG_DATA_W-1:0] pat_hi  = '0;
    logic [16:0]           nfa_pos = 17'd1;

    char_tag_t char_tags_q [$];
    logic      verdict_q [$];

    int  fails         = 0;
    int  cycles        = 0;
    int  chars_sent    = 0;
    int  hits          = 0;
    int  misses        = 0;
    int  settings_used = 0;
    int  stall_left    = 0;
    bit  calm_phase    = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        // Registers at reset: an empty pattern accepts only the empty string.
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, SLASH_CHAR, 1'b1, 1'b1, 1'b1},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b1, 1'b1, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'hFF,      1'b1, 1'b1, 1'b0},
        // Oversized length over sixteen stars accepts anything.
        '{ROW_CFG,  REG_PATTERN_LENGTH, 64'h1F, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_LOW,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_HIGH, 64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h01,      1'b1, 1'b1, 1'b1},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, SLASH_CHAR, 1'b1, 1'b1, 1'b1},
        // Pattern "a*b?".
        '{ROW_CFG,  REG_PATTERN_LENGTH, 64'h4, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_LOW,  64'h0000_0000_3F62_2A61, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_HIGH, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h78,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h62,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h7A,      1'b1, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h62,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, SLASH_CHAR, 1'b1, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h62,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h63,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, SLASH_CHAR, 1'b1, 1'b0, 1'b0},
        // Shorten the pattern to "a*" in the middle of a string.
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h62,      1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_PATTERN_LENGTH, 64'h2, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h71,      1'b1, 1'b0, 1'b0},
        // Zero bytes in the pattern are plain literals that only a zero text byte would meet.
        '{ROW_CFG,  REG_PATTERN_LENGTH, 64'h10, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_LOW,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h61,      1'b1, 1'b1, 1'b0},
        '{ROW_CFG,  REG_CHARS_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_PATTERN_LENGTH, 64'h1, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'hFF,      1'b1, 1'b1, 1'b1},
        // A lone '?' needs exactly one character; a bare slash is empty.
        '{ROW_CFG,  REG_CHARS_LOW,  64'h3F, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, 8'h7A,      1'b1, 1'b1, 1'b1},
        '{ROW_TEXT, REG_PATTERN_LENGTH, 64'h0, SLASH_CHAR, 1'b1, 1'b1, 1'b0}
    };

    function automatic int eff_len();
        return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_char(input int i);
        return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
    endfunction

    // Drop positions past the pattern end, then let every reached star
    // also reach the position after it.
    function automatic logic [16:0] star_close(input logic [16:0] s, input int n);
        logic [17:0] mask;
        logic [16:0] r;
        mask = (18'd1 << (n + 1)) - 18'd1;
        r    = s & mask[16:0];
        for (int p = 0; p < n; p++) begin
            if (r[p] && pat_char(p) == STAR_CHAR) begin
                r[p+1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] nfa_advance(input logic [16:0] s, input int n,
                                               input logic [7:0] c);
        logic [16:0] cur;
        logic [16:0] nxt;
        logic [7:0]  pc;
        cur = star_close(s, n);
        nxt = '0;
        for (int p = 0; p < n; p++) begin
            if (cur[p]) begin
                pc = pat_char(p);
                if (pc == STAR_CHAR) begin
                    nxt[p] = 1'b1;
                end else if (pc == ANY_CHAR || pc == c) begin
                    nxt[p+1] = 1'b1;
                end
            end
        end
        return star_close(nxt, n);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 99) < 80) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic typed, input logic want);
        int g;
        char_tags_q.push_back('{typed, want});
        s_tdata  <= ch;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        g = calm_phase ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Leaves cfg_valid high when another write follows at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val,
                             input bit more);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (!more) begin
            cfg_valid <= 1'b0;
        end
        case (idx)
            REG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
            REG_CHARS_LOW:      pat_lo  = val;
            REG_CHARS_HIGH:     pat_hi  = val;
            default: ;
        endcase
    endtask

    // Wait for every outstanding verdict, then give the last character
    // time to settle in the block.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (char_tags_q.size() != 0 || verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase();
        logic [7:0]            pc [16];
        logic [63:0]           lo;
        logic [63:0]           hi;
        logic [CFG_IDX_W-1:0]  w_idx [$];
        logic [63:0]           w_val [$];
        logic [7:0]            txt [$];
        logic [7:0]            c;
        int                    r;
        int                    len_pick;
        int                    n;
        r = $urandom_range(0, 99);
        if (r < 10)      len_pick = 0;
        else if (r < 22) len_pick = MAX_PATTERN_DEF;
        else if (r < 28) len_pick = $urandom_range(17, 31);
        else             len_pick = $urandom_range(1, 8);
        for (int i = 0; i < 16; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25)      pc[i] = STAR_CHAR;
            else if (r < 45) pc[i] = ANY_CHAR;
            else if (r < 85) pc[i] = 8'h61 + 8'($urandom_range(0, 2));
            else if (r < 92) pc[i] = 8'h00;
            else             pc[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = pc[i];
            hi[i*8 +: 8] = pc[i+8];
        end
        if ($urandom_range(0, 9) == 0) lo = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) hi = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            w_idx.push_back(REG_PATTERN_LENGTH);
            w_val.push_back(64'(len_pick));
        end
        if ($urandom_range(0, 3) != 0) begin
            w_idx.push_back(REG_CHARS_LOW);
            w_val.push_back(lo);
        end
        if ($urandom_range(0, 3) != 0) begin
            w_idx.push_back(REG_CHARS_HIGH);
            w_val.push_back(hi);
        end
        if (w_idx.size() == 0) begin
            w_idx.push_back(REG_PATTERN_LENGTH);
            w_val.push_back(64'(len_pick));
        end

        wait_quiet();
        calm_phase = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < w_idx.size(); k++) begin
            write_reg(w_idx[k], w_val[k], k + 1 < w_idx.size());
        end
        settings_used++;

        n = eff_len();
        repeat ($urandom_range(5, 30)) begin
            txt.delete();
            if ($urandom_range(0, 99) < 65) begin
                // Spell out a string along the pattern, with 'a' for zero bytes, then maybe spoil it.
                for (int p = 0; p < n; p++) begin
                    c = pat_char(p);
                    if (c == STAR_CHAR) begin
                        repeat ($urandom_range(0, 3)) txt.push_back(text_char());
                    end else if (c == ANY_CHAR) begin
                        txt.push_back(text_char());
                    end else if (c == 8'h00) begin
                        txt.push_back(8'h61);
                    end else begin
                        txt.push_back(c);
                    end
                end
                if (txt.size() != 0 && $urandom_range(0, 3) == 0) begin
                    txt[$urandom_range(0, txt.size() - 1)] = text_char();
                end
            end else begin
                repeat ($urandom_range(0, 8)) txt.push_back(text_char());
            end
            if (txt.size() == 0 || $urandom_range(0, 6) == 0) begin
                txt.push_back(SLASH_CHAR);
            end
            foreach (txt[i]) begin
                send_char(txt[i], i == txt.size() - 1, 1'b0, 1'b0);
            end
        end
        // Sometimes leave a string open so the next setting lands mid-string.
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(text_char(), 1'b0, 1'b0, 1'b0);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : track
        char_tag_t   tag;
        logic [16:0] s;
        int          n;
        logic        hit;
        logic        want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tag = char_tags_q.pop_front();
                n   = eff_len();
                s   = nfa_pos;
                // A slash on the last character is stripped, not consumed.
                if (!(s_tlast && s_tdata == SLASH_CHAR)) begin
                    s = nfa_advance(s, n, s_tdata);
                end
                if (!s_tlast) begin
                    nfa_pos = s;
                end else begin
                    s       = star_close(s, n);
                    hit     = s[n];
                    nfa_pos = 17'd1;
                    verdict_q.push_back(tag.typed ? tag.want : hit);
                end
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no string pending: matched=%0b", m_tdata[0]);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want) hits++;
                    else      misses++;
                    if (m_tdata[0] !== want) begin
                        $error("matched: expected %0b, got %0b", want, m_tdata[0]);
                        fails++;
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        $error("tdata[7:1]: expected 0, got %0h", m_tdata[7:1]);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("glob_wildcard_matcher_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int rand_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                if (k == 0 || dir_rows[k-1].kind != ROW_CFG) begin
                    wait_quiet();
                end
                write_reg(dir_rows[k].reg_idx, dir_rows[k].value,
                          k + 1 < DIR_N && dir_rows[k+1].kind == ROW_CFG);
            end else begin
                send_char(dir_rows[k].ch, dir_rows[k].last, dir_rows[k].typed,
                          dir_rows[k].want);
            end
        end

        rand_start = chars_sent;
        while (chars_sent - rand_start < RANDOM_CHARS) begin
            run_phase();
        end

        wait_quiet();
        repeat (8) @(posedge aclk);
        $display("Checked %0d verdicts (%0d matched, %0d not) over %0d characters.",
                 hits + misses, hits, misses, chars_sent);
        $display("Patterns came from %0d random register settings plus the directed ones.",
                 settings_used);
        if (fails == 0) begin
            $display("glob_wildcard_matcher_unit: match");
        end else begin
            $display("glob_wildcard_matcher_unit: mismatch");
        end
        $finish;
    end

endmodule
